// File: rtl/okvt_pkg.sv
// Package for the ordered key/value table: request and status codes, controller
// states and the per-cell command struct.
// No dependencies; used by every file of the block.
package okvt_pkg;

    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int LIVE_W     = 7;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 4;
    localparam int S_DATA_W   = KEY_W + VAL_W;
    localparam int M_DATA_W   = 136;  // key, value, live count, zero pad to bytes
    localparam int MAX_ENTRIES = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_LIST   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED          = 4'd0,
        STAT_OVERRIDDEN     = 4'd1,
        STAT_FULL           = 4'd2,
        STAT_FOUND          = 4'd3,
        STAT_NOT_FOUND      = 4'd4,
        STAT_REMOVED        = 4'd5,
        STAT_REMOVE_MISSED  = 4'd6,
        STAT_LISTED         = 4'd7,
        STAT_EMPTY          = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        STATE_IDLE,
        STATE_EXEC,
        STATE_LIST
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_VALUE,
        CELL_LOAD_ENTRY,
        CELL_TAKE_NEXT,
        CELL_TAKE_HEAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     compare;
    } cell_ctrl_t;

endpackage

// File: rtl/ordered_key_value_table_unit.sv
// Top level of the ordered key/value table: request controller, chain of cells
// and registered result stage.
// Depends on okvt_pkg and okvt_cell.

// The table keeps up to ENTRIES key/value pairs in insertion order inside a
// row of cells, each cell holding one pair and comparing it against the
// request key in parallel. A request is a transfer on the s_ side: tuser
// carries the request kind, tdata the key and the new value. Add-or-update,
// lookup and remove each pass through the idle and exec states: the accept
// cycle registers every cell's compare result, and the exec state, once the
// output register is free, updates the cells and loads one result into it.
// Remove closes the gap by having every live cell from the match upward take
// its upper neighbor's pair in the same cycle that loads the result.
// A list request rotates the chain by one cell per cycle while the output
// register is free, the head cell's pair goes out on each turn, and after n
// turns for n live entries the table is back in its original order. An empty
// list gives one empty status. Results leave as transfers on the m_ side
// with tlast on the final result of each request; the output register holds
// a stalled result while the controller waits, and no new request is taken
// until the current one has produced its last result.
module ordered_key_value_table_unit #(
    parameter int ENTRIES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [okvt_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
    input  logic [okvt_pkg::S_DATA_W-1:0]   s_tdata,   // [63:0] key, [127:64] new_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [okvt_pkg::STATUS_W-1:0]   m_tuser,   // [3:0] status
    output logic [okvt_pkg::M_DATA_W-1:0]   m_tdata,   // [63:0] out_key, [127:64] out_value,
                                                       // [134:128] live_count, [135] zero
    output logic                            m_tlast
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    // ---------------------------------------------------------------
    // Request registers and control state
    // ---------------------------------------------------------------
    okvt_pkg::state_t            state_reg, state_next;
    okvt_pkg::req_t              req_type_reg;
    logic [okvt_pkg::KEY_W-1:0]  req_key_reg;
    logic [okvt_pkg::VAL_W-1:0]  req_val_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            list_idx_reg, list_idx_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    okvt_pkg::status_t           m_status_reg;
    logic [okvt_pkg::KEY_W-1:0]  m_key_reg;
    logic [okvt_pkg::VAL_W-1:0]  m_val_reg;
    logic [CNT_W-1:0]            m_count_reg;
    logic                        m_last_reg;

    // ---------------------------------------------------------------
    // Cell chain signals
    // ---------------------------------------------------------------
    okvt_pkg::cell_ctrl_t        cell_ctrl [ENTRIES];
    logic [okvt_pkg::KEY_W-1:0]  cell_key  [ENTRIES];
    logic [okvt_pkg::VAL_W-1:0]  cell_val  [ENTRIES];
    logic [ENTRIES-1:0]          hit_vec;
    logic [ENTRIES-1:0]          live_vec;
    logic [ENTRIES-1:0]          shift_mask;
    logic                        hit_any;
    logic [okvt_pkg::KEY_W-1:0]  sel_key;
    logic [okvt_pkg::VAL_W-1:0]  sel_val;

    // controller outputs
    logic                        accept;
    logic                        out_free;
    logic                        out_load;
    okvt_pkg::status_t           res_status;
    logic [okvt_pkg::KEY_W-1:0]  res_key;
    logic [okvt_pkg::VAL_W-1:0]  res_val;
    logic                        res_last;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            assign live_vec[g] = (CNT_W'(g) < count_reg);

            okvt_cell u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl[g]),
                .live     (live_vec[g]),
                .cmp_key  (s_tdata[okvt_pkg::KEY_W-1:0]),
                .req_key  (req_key_reg),
                .req_val  (req_val_reg),
                .nbr_key  (cell_key[(g + 1) % ENTRIES]),
                .nbr_val  (cell_val[(g + 1) % ENTRIES]),
                .head_key (cell_key[0]),
                .head_val (cell_val[0]),
                .key_q    (cell_key[g]),
                .val_q    (cell_val[g]),
                .hit      (hit_vec[g])
            );
        end
    endgenerate

    assign hit_any = |hit_vec;
    // cells at and above the single match; empty when nothing hit
    assign shift_mask = hit_any ? ~(hit_vec - ENTRIES'(1)) : '0;

    // select the matching pair (one-hot, so a plain OR of masked pairs)
    always_comb begin
        sel_key = '0;
        sel_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
                sel_key = sel_key | cell_key[i];
                sel_val = sel_val | cell_val[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            okvt_pkg::STATE_IDLE: begin
                if (accept) begin
                    state_next = okvt_pkg::STATE_EXEC;
                end
            end
            okvt_pkg::STATE_EXEC: begin
                if (req_type_reg == okvt_pkg::REQ_LIST && count_reg != '0) begin
                    state_next = okvt_pkg::STATE_LIST;
                end else if (out_free) begin
                    state_next = okvt_pkg::STATE_IDLE;
                end
            end
            okvt_pkg::STATE_LIST: begin
                if (out_free && list_idx_reg == count_reg - CNT_W'(1)) begin
                    state_next = okvt_pkg::STATE_IDLE;
                end
            end
            default: begin
                state_next = okvt_pkg::STATE_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Controller outputs: cell commands, result and count updates
    // ---------------------------------------------------------------
    always_comb begin
        s_tready      = 1'b0;
        out_load      = 1'b0;
        res_status    = okvt_pkg::STAT_EMPTY;
        res_key       = '0;
        res_val       = '0;
        res_last      = 1'b1;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            cell_ctrl[i].op      = okvt_pkg::CELL_HOLD;
            cell_ctrl[i].compare = 1'b0;
        end

        case (state_reg)
            okvt_pkg::STATE_IDLE: begin
                s_tready = 1'b1;
                for (int i = 0; i < ENTRIES; i++) begin
                    cell_ctrl[i].compare = accept;
                end
            end
            okvt_pkg::STATE_EXEC: begin
                list_idx_next = '0;
                case (req_type_reg)
                    okvt_pkg::REQ_ADD: begin
                        out_load = out_free;
                        if (hit_any) begin
                            res_status = okvt_pkg::STAT_OVERRIDDEN;
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (hit_vec[i] && out_free) begin
                                    cell_ctrl[i].op = okvt_pkg::CELL_LOAD_VALUE;
                                end
                            end
                        end else if (count_reg < CNT_W'(ENTRIES)) begin
                            res_status = okvt_pkg::STAT_ADDED;
                            if (out_free) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (CNT_W'(i) == count_reg && out_free) begin
                                    cell_ctrl[i].op = okvt_pkg::CELL_LOAD_ENTRY;
                                end
                            end
                        end else begin
                            res_status = okvt_pkg::STAT_FULL;
                        end
                    end
                    okvt_pkg::REQ_LOOKUP: begin
                        out_load = out_free;
                        if (hit_any) begin
                            res_status = okvt_pkg::STAT_FOUND;
                            res_key    = sel_key;
                            res_val    = sel_val;
                        end else begin
                            res_status = okvt_pkg::STAT_NOT_FOUND;
                        end
                    end
                    okvt_pkg::REQ_REMOVE: begin
                        out_load = out_free;
                        if (hit_any) begin
                            res_status = okvt_pkg::STAT_REMOVED;
                            if (out_free) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            // close the gap: every live cell from the match up
                            // takes its upper neighbor's pair
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (shift_mask[i] && out_free &&
                                    CNT_W'(i) < count_reg - CNT_W'(1)) begin
                                    cell_ctrl[i].op = okvt_pkg::CELL_TAKE_NEXT;
                                end
                            end
                        end else begin
                            res_status = okvt_pkg::STAT_REMOVE_MISSED;
                        end
                    end
                    okvt_pkg::REQ_LIST: begin
                        // a non-empty list hands over to the rotation state
                        if (count_reg == '0) begin
                            out_load   = out_free;
                            res_status = okvt_pkg::STAT_EMPTY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            okvt_pkg::STATE_LIST: begin
                out_load   = out_free;
                res_status = okvt_pkg::STAT_LISTED;
                res_key    = cell_key[0];
                res_val    = cell_val[0];
                res_last   = (list_idx_reg == count_reg - CNT_W'(1));
                if (out_free) begin
                    list_idx_next = list_idx_reg + CNT_W'(1);
                    // rotate the live part of the chain by one toward the head
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (CNT_W'(i) < count_reg - CNT_W'(1)) begin
                            cell_ctrl[i].op = okvt_pkg::CELL_TAKE_NEXT;
                        end else if (CNT_W'(i) == count_reg - CNT_W'(1)) begin
                            cell_ctrl[i].op = okvt_pkg::CELL_TAKE_HEAD;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= okvt_pkg::STATE_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // request capture and result payload: no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= okvt_pkg::req_t'(s_tuser);
            req_key_reg  <= s_tdata[okvt_pkg::KEY_W-1:0];
            req_val_reg  <= s_tdata[okvt_pkg::S_DATA_W-1:okvt_pkg::KEY_W];
        end
        if (out_load) begin
            m_status_reg <= res_status;
            m_key_reg    <= res_key;
            m_val_reg    <= res_val;
            m_count_reg  <= count_next;
            m_last_reg   <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, okvt_pkg::LIVE_W'(m_count_reg), m_val_reg, m_key_reg};

endmodule

// File: rtl/okvt_cell.sv
// One table cell: holds a key/value pair, compares against a request key and
// loads from the request, its upper neighbor or the head of the chain.
// Depends on okvt_pkg.
module okvt_cell (
    input  logic                        aclk,
    input  okvt_pkg::cell_ctrl_t        ctrl,
    input  logic                        live,
    input  logic [okvt_pkg::KEY_W-1:0]  cmp_key,
    input  logic [okvt_pkg::KEY_W-1:0]  req_key,
    input  logic [okvt_pkg::VAL_W-1:0]  req_val,
    input  logic [okvt_pkg::KEY_W-1:0]  nbr_key,
    input  logic [okvt_pkg::VAL_W-1:0]  nbr_val,
    input  logic [okvt_pkg::KEY_W-1:0]  head_key,
    input  logic [okvt_pkg::VAL_W-1:0]  head_val,
    output logic [okvt_pkg::KEY_W-1:0]  key_q,
    output logic [okvt_pkg::VAL_W-1:0]  val_q,
    output logic                        hit
);

    logic [okvt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [okvt_pkg::VAL_W-1:0] val_reg, val_next;
    logic                       hit_reg, hit_next;

    always_comb begin
        key_next = key_reg;
        val_next = val_reg;
        case (ctrl.op)
            okvt_pkg::CELL_HOLD: begin
            end
            okvt_pkg::CELL_LOAD_VALUE: begin
                val_next = req_val;
            end
            okvt_pkg::CELL_LOAD_ENTRY: begin
                key_next = req_key;
                val_next = req_val;
            end
            okvt_pkg::CELL_TAKE_NEXT: begin
                key_next = nbr_key;
                val_next = nbr_val;
            end
            okvt_pkg::CELL_TAKE_HEAD: begin
                key_next = head_key;
                val_next = head_val;
            end
            default: begin
            end
        endcase
    end

    // only live cells may match; keys are unique so at most one hits
    assign hit_next = ctrl.compare ? (live && (cmp_key == key_reg)) : hit_reg;

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
        hit_reg <= hit_next;
    end

    assign key_q = key_reg;
    assign val_q = val_reg;
    assign hit   = hit_reg;

endmodule

// File: rtl/okvt_checker.sv
// Port-level checker for the ordered key/value table, with its bind to the
// top level. Depends on okvt_pkg.
module okvt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [okvt_pkg::STATUS_W-1:0]   m_tuser,
    input logic [okvt_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);

    // hold a stalled result unchanged
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // every request other than a list gives exactly one result
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != okvt_pkg::STAT_LISTED |-> m_tlast)
        else $error("single result without tlast");

    // only found and listed results carry a pair
    a_zero_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != okvt_pkg::STAT_FOUND && m_tuser != okvt_pkg::STAT_LISTED
            |-> m_tdata[127:0] == '0)
        else $error("pair on a status-only result");

    // empty status only with no live entries; listed only with some
    a_count_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != okvt_pkg::STAT_EMPTY || m_tdata[134:128] == '0)
            && (m_tuser != okvt_pkg::STAT_LISTED || m_tdata[134:128] != '0)
            && m_tdata[134:128] <= 7'(okvt_pkg::MAX_ENTRIES))
        else $error("live count inconsistent with status");

endmodule

bind ordered_key_value_table_unit okvt_checker u_okvt_checker (.*);
